### hw/rtl/gadc_pkg.sv
package gadc_pkg;

  // defaults for the top level parameters
  localparam int BUTTON_COUNT_DEF = 12;
  localparam int ANGLE_ITERS_DEF  = 14;

  // field widths
  localparam int AXIS_W  = 16;
  localparam int MAG_W   = 16;
  localparam int BTN_W   = 12;
  localparam int ANGLE_W = 16;
  localparam int AIM_W   = MAG_W + 1;

  // conditioning: dividend (|c| - dead zone) * 4 + 1, divided by three one bit a cycle
  localparam int               DIVD_W    = 17;
  localparam logic [MAG_W-1:0] DEAD_ZONE = 16'd8192;
  localparam logic [MAG_W-1:0] CENTER    = 16'h8000;
  localparam logic [2:0]       DIVISOR   = 3'd3;

  // fire test: 100 * (a0^2 + a1^2) > 2^30 is sum > 10737418
  localparam int             SQ_W       = 32;
  localparam logic [SQ_W:0]  FIRE_LIMIT = 33'd10737418;

  // angle datapath
  localparam int CORDIC_W     = 27;
  localparam int AIM_SHIFT    = 8;
  localparam int ZW           = 17;
  localparam int ATAN_LEN     = 20;
  localparam int ATAN_AW      = 5;
  localparam int ATAN_W       = 13;
  localparam logic signed [ZW-1:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [ZW-1:0] PI_Q13      = 17'sd25736;

  typedef enum logic [1:0] {
    MAP_RZ_SLIDER = 2'd0,
    MAP_RZ_Z      = 2'd1,
    MAP_Z_RZ      = 2'd2,
    MAP_RX_RY     = 2'd3
  } axis_map_t;

  typedef struct packed {
    logic              poll_ok;
    logic [AXIS_W-1:0] axis_x;
    logic [AXIS_W-1:0] axis_y;
    logic [AXIS_W-1:0] axis_z;
    logic [AXIS_W-1:0] axis_rot_x;
    logic [AXIS_W-1:0] axis_rot_y;
    logic [AXIS_W-1:0] axis_rot_z;
    logic [AXIS_W-1:0] slider_zero;
    logic [BTN_W-1:0]  raw_buttons;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0]          move_left;
    logic [MAG_W-1:0]          move_right;
    logic [MAG_W-1:0]          move_up;
    logic [MAG_W-1:0]          move_down;
    logic signed [ANGLE_W-1:0] aim_angle;
    logic                      fire;
    logic [BTN_W-1:0]          buttons_now;
    logic [BTN_W-1:0]          pressed_edges;
    logic [BTN_W-1:0]          released_edges;
  } out_item_t;

  // arctan(2^-i) in Q3.13, rounded
  function automatic logic [ATAN_W-1:0] atan_q13(input logic [ATAN_AW-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 13'd6434;
      5'd1:    v = 13'd3798;
      5'd2:    v = 13'd2007;
      5'd3:    v = 13'd1019;
      5'd4:    v = 13'd511;
      5'd5:    v = 13'd256;
      5'd6:    v = 13'd128;
      5'd7:    v = 13'd64;
      5'd8:    v = 13'd32;
      5'd9:    v = 13'd16;
      5'd10:   v = 13'd8;
      5'd11:   v = 13'd4;
      5'd12:   v = 13'd2;
      5'd13:   v = 13'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/gadc_if.sv
interface gadc_in_if import gadc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface gadc_out_if import gadc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### hw/rtl/gadc_lane.sv
module gadc_lane import gadc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [AXIS_W-1:0] raw,
  output logic              busy,
  output logic [MAG_W-1:0]  mag,
  output logic              neg
);

  localparam int CW = $clog2(DIVD_W + 1);

  logic [MAG_W-1:0]  c_mag;
  logic [MAG_W-1:0]  c_over;
  logic [DIVD_W-1:0] dividend;
  logic [2:0]        rem_ext;
  logic              q_bit;
  logic [1:0]        rem_nxt;

  logic [DIVD_W-1:0] n_r;
  logic [DIVD_W-1:0] q_r;
  logic [1:0]        rem_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              neg_r;

  // distance from center and dead zone removal, times four plus one
  always_comb begin
    c_mag    = raw[AXIS_W-1] ? {1'b0, raw[AXIS_W-2:0]} : CENTER - raw;
    c_over   = c_mag - DEAD_ZONE;
    dividend = (c_mag > DEAD_ZONE) ? {c_over[DIVD_W-3:0], 2'b01} : '0;
  end

  // restoring division by three, msb first
  always_comb begin
    rem_ext = {rem_r, n_r[DIVD_W-1]};
    q_bit   = rem_ext >= DIVISOR;
    rem_nxt = q_bit ? 2'(rem_ext - DIVISOR) : rem_ext[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DIVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      q_r   <= '0;
      rem_r <= '0;
      neg_r <= ~raw[AXIS_W-1];
    end else if (busy_r) begin
      n_r   <= {n_r[DIVD_W-2:0], 1'b0};
      q_r   <= {q_r[DIVD_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign mag  = q_r[MAG_W-1:0];
  assign neg  = neg_r;

endmodule

### hw/rtl/gadc_sqr.sv
module gadc_sqr import gadc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  output logic             busy,
  output logic [SQ_W-1:0]  sq
);

  localparam int CW = $clog2(MAG_W + 1);

  logic [SQ_W-1:0]  mc_r;
  logic [MAG_W-1:0] mp_r;
  logic [SQ_W-1:0]  acc_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(MAG_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= SQ_W'(mag);
      mp_r  <= mag;
      acc_r <= '0;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= {mc_r[SQ_W-2:0], 1'b0};
      mp_r <= {1'b0, mp_r[MAG_W-1:1]};
    end
  end

  assign busy = busy_r;
  assign sq   = acc_r;

endmodule

### hw/rtl/gadc_cordic.sv
module gadc_cordic import gadc_pkg::*; #(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [AIM_W-1:0]   ay,
  input  logic signed [AIM_W-1:0]   ax,
  output logic                      busy,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int IW = $clog2(ANGLE_ITERATIONS);

  logic signed [CORDIC_W-1:0] x_in;
  logic signed [CORDIC_W-1:0] y_in;
  logic signed [CORDIC_W-1:0] x_ld;
  logic signed [CORDIC_W-1:0] y_ld;
  logic signed [ZW-1:0]       z_ld;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [ZW-1:0]       at;

  logic signed [CORDIC_W-1:0] x_r;
  logic signed [CORDIC_W-1:0] y_r;
  logic signed [ZW-1:0]       z_r;
  logic [IW-1:0]              i_r;
  logic                       busy_r;

  // scale up and pre-rotate into the right half plane
  always_comb begin
    x_in = CORDIC_W'(ax) <<< AIM_SHIFT;
    y_in = CORDIC_W'(ay) <<< AIM_SHIFT;
    x_ld = x_in;
    y_ld = y_in;
    z_ld = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x_ld = y_in;
        y_ld = -x_in;
        z_ld = HALF_PI_Q13;
      end else begin
        x_ld = -y_in;
        y_ld = x_in;
        z_ld = -HALF_PI_Q13;
      end
    end
  end

  always_comb begin
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = {{(ZW-ATAN_W){1'b0}}, atan_q13(ATAN_AW'(i_r))};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r    <= '0;
    end else if (busy_r) begin
      i_r <= i_r + 1'b1;
      if (i_r == IW'(ANGLE_ITERATIONS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // one vectoring micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_ld;
      y_r <= y_ld;
      z_r <= z_ld;
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end
    end
  end

  always_comb begin
    if (z_r > PI_Q13) begin
      angle = ANGLE_W'(PI_Q13);
    end else if (z_r < -PI_Q13) begin
      angle = ANGLE_W'(-PI_Q13);
    end else begin
      angle = ANGLE_W'(z_r);
    end
  end

  assign busy = busy_r;

endmodule

### hw/rtl/gamepad_axis_deadzone_conditioner_core.sv
// each poll runs through the bit-serial divide-by-three in the lanes, then the bit-serial
//   squarers and the cordic side by side, then into the output register
// a new poll is taken only once the last one has been handed to the output register
// a failed poll is taken and gives no item
// reset (rst_n low, synchronous): control idle, axis mapping 0, previous buttons released
module gamepad_axis_deadzone_conditioner_core import gadc_pkg::*; #(
  parameter int BUTTON_COUNT     = BUTTON_COUNT_DEF,
  parameter int ANGLE_ITERATIONS = ANGLE_ITERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  gadc_in_if.sink    in_chan,
  gadc_out_if.source out_chan
);

  // buttons beyond BUTTON_COUNT are ignored
  localparam logic [BTN_W-1:0] BTN_MASK = (BUTTON_COUNT >= BTN_W) ? '1
                                          : BTN_W'((64'd1 << BUTTON_COUNT) - 64'd1);

  // source bit for each of the low eight buttons in the rx/ry layout
  localparam int REMAP_N = 8;
  localparam int REMAP_SRC [REMAP_N] = '{2, 0, 5, 3, 1, 4, 10, 11};

  // lane order
  localparam int LANE_X    = 0;
  localparam int LANE_Y    = 1;
  localparam int LANE_AIM0 = 2;
  localparam int LANE_AIM1 = 3;
  localparam int LANES     = 4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t    state_r, state_nxt;
  axis_map_t map_r;

  logic [BTN_W-1:0] prev_btn_r;
  logic [BTN_W-1:0] btn_now_r;
  logic [BTN_W-1:0] pressed_r;
  logic [BTN_W-1:0] released_r;

  logic      out_valid_r;
  out_item_t out_item_r;

  // lane wiring
  logic [AXIS_W-1:0] lane_raw  [LANES];
  logic [MAG_W-1:0]  lane_mag  [LANES];
  logic              lane_neg  [LANES];
  logic              lane_busy [LANES];

  logic in_acc;
  logic start_div;
  logic start_aim;
  logic units_busy;
  logic units_done;
  logic out_free;
  logic load_out;

  logic [BTN_W-1:0] raw_btn;
  logic [BTN_W-1:0] remap_btn;
  logic [BTN_W-1:0] now_btn;

  logic signed [AIM_W-1:0]   aim0;
  logic signed [AIM_W-1:0]   aim1;
  logic [SQ_W-1:0]           sq0;
  logic [SQ_W-1:0]           sq1;
  logic                      sq0_busy;
  logic                      sq1_busy;
  logic                      co_busy;
  logic signed [ANGLE_W-1:0] co_angle;
  logic [SQ_W:0]             sq_sum;
  logic                      fire;
  out_item_t                 res;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign start_div     = in_acc && in_chan.item.poll_ok;

  // aim channel selection follows the controller layout
  always_comb begin
    lane_raw[LANE_X] = in_chan.item.axis_x;
    lane_raw[LANE_Y] = in_chan.item.axis_y;
    case (map_r)
      MAP_RZ_SLIDER: begin
        lane_raw[LANE_AIM0] = in_chan.item.axis_rot_z;
        lane_raw[LANE_AIM1] = in_chan.item.slider_zero;
      end
      MAP_RZ_Z: begin
        lane_raw[LANE_AIM0] = in_chan.item.axis_rot_z;
        lane_raw[LANE_AIM1] = in_chan.item.axis_z;
      end
      MAP_Z_RZ: begin
        lane_raw[LANE_AIM0] = in_chan.item.axis_z;
        lane_raw[LANE_AIM1] = in_chan.item.axis_rot_z;
      end
      default: begin
        lane_raw[LANE_AIM0] = in_chan.item.axis_rot_x;
        lane_raw[LANE_AIM1] = in_chan.item.axis_rot_y;
      end
    endcase
  end

  // four conditioning lanes run side by side, one quotient bit per cycle
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    gadc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (start_div),
      .raw   (lane_raw[g]),
      .busy  (lane_busy[g]),
      .mag   (lane_mag[g]),
      .neg   (lane_neg[g])
    );
  end

  // signed aim values for the angle unit
  assign aim0 = lane_neg[LANE_AIM0] ? -AIM_W'(lane_mag[LANE_AIM0])
                                    : AIM_W'(lane_mag[LANE_AIM0]);
  assign aim1 = lane_neg[LANE_AIM1] ? -AIM_W'(lane_mag[LANE_AIM1])
                                    : AIM_W'(lane_mag[LANE_AIM1]);

  // squarers and angle start together once the lanes have settled
  assign start_aim = (state_r == ST_DIV) && !lane_busy[LANE_X];

  gadc_sqr u_sqr0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_aim),
    .mag   (lane_mag[LANE_AIM0]),
    .busy  (sq0_busy),
    .sq    (sq0)
  );

  gadc_sqr u_sqr1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_aim),
    .mag   (lane_mag[LANE_AIM1]),
    .busy  (sq1_busy),
    .sq    (sq1)
  );

  gadc_cordic #(
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_aim),
    .ay    (aim0),
    .ax    (aim1),
    .busy  (co_busy),
    .angle (co_angle)
  );

  assign units_busy = sq0_busy || sq1_busy || co_busy;
  assign units_done = (state_r == ST_RUN) && !units_busy;
  assign out_free   = !out_valid_r || out_chan.ready;
  assign load_out   = (units_done || (state_r == ST_HOLD)) && out_free;

  // sequencer: divide, then square and rotate, then hand over to the output register
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_div) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (start_aim) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (units_done) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // button mask, optional remap for the rx/ry layout
  always_comb begin
    raw_btn   = in_chan.item.raw_buttons & BTN_MASK;
    remap_btn = '0;
    for (int i = 0; i < REMAP_N; i++) begin
      remap_btn[i] = raw_btn[REMAP_SRC[i]];
    end
    now_btn = (map_r == MAP_RX_RY) ? (remap_btn & BTN_MASK) : raw_btn;
  end

  // exact fire test on the squared length, angle forced to zero when not firing
  always_comb begin
    sq_sum         = {1'b0, sq0} + {1'b0, sq1};
    fire           = sq_sum > FIRE_LIMIT;
    res.move_left  = lane_neg[LANE_X] ? lane_mag[LANE_X] : '0;
    res.move_right = lane_neg[LANE_X] ? '0 : lane_mag[LANE_X];
    res.move_up    = lane_neg[LANE_Y] ? lane_mag[LANE_Y] : '0;
    res.move_down  = lane_neg[LANE_Y] ? '0 : lane_mag[LANE_Y];
    res.aim_angle  = fire ? co_angle : '0;
    res.fire       = fire;
    res.buttons_now    = btn_now_r;
    res.pressed_edges  = pressed_r;
    res.released_edges = released_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      map_r       <= MAP_RZ_SLIDER;
      prev_btn_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        map_r <= axis_map_t'(cfg_wr_data);
      end
      if (start_div) begin
        prev_btn_r <= now_btn;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // button results are settled at accept and wait for the arithmetic
  always_ff @(posedge clk) begin
    if (start_div) begin
      btn_now_r  <= now_btn;
      pressed_r  <= now_btn & ~prev_btn_r;
      released_r <= prev_btn_r & ~now_btn;
    end
    if (load_out) begin
      out_item_r <= res;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.item  = out_item_r;

endmodule

### hw/rtl/gadc_checker.sv
module gadc_checker import gadc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      in_poll_ok,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // a good poll occupies the block
  a_busy_after_poll: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_poll_ok |=> !in_ready)
    else $error("input taken while a poll is in work");

  a_move_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.move_left == '0 || out_item.move_right == '0) &&
                  (out_item.move_up == '0 || out_item.move_down == '0))
    else $error("both directions of one move axis set");

  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.pressed_edges & ~out_item.buttons_now) == '0) &&
                  ((out_item.released_edges & out_item.buttons_now) == '0))
    else $error("button edges disagree with current mask");

  a_angle_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.fire |-> out_item.aim_angle == '0)
    else $error("angle nonzero without fire");

endmodule

bind gamepad_axis_deadzone_conditioner_core gadc_checker u_gadc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_poll_ok (in_chan.item.poll_ok),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_item   (out_chan.item)
);

### tb/sv/tb_gamepad_axis_deadzone_conditioner_core.sv
module tb_gamepad_axis_deadzone_conditioner_core;
  import gadc_pkg::*;

  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 9;
  // settle wait, longer than one poll takes with the default parameters
  localparam int SETTLE_CYCLES    = 40;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int RANDOM_POLLS     = 400;
  localparam int RANDOM_PHASES    = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PRESSURE_POLLS   = 12;

  // axis conditioning constants, kept as signed ints for the predictor
  localparam int MID          = 32768;
  localparam int DZ           = 8192;
  localparam int QUARTER_TURN = 12868;
  localparam int HALF_TURN    = 25736;
  localparam int ANGLE_STEPS  = ANGLE_ITERS_DEF;

  // raw axis at rest
  localparam logic [AXIS_W-1:0] MID_RAW = 16'd32768;

  // raw axis values just around the fire threshold (conditioned 3277 and 3276)
  localparam logic [AXIS_W-1:0] AIM_FIRE_RAW  = 16'd43418;
  localparam logic [AXIS_W-1:0] AIM_QUIET_RAW = 16'd43417;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [1:0]       cfg_wr_data;

  gadc_in_if  in_if ();
  gadc_out_if out_if ();

  gamepad_axis_deadzone_conditioner_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_chan    (in_if),
    .out_chan   (out_if)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // arctan(2^-i) in q3.13, rounded to nearest
  int arctan_q13 [0:19] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16,
                            8, 4, 2, 1, 0, 0, 0, 0, 0, 0};

  // predictor state: its own copy of the mapping register and the button history
  axis_map_t        model_map;
  logic [BTN_W-1:0] model_prev_buttons;
  out_item_t        pending_reports [$];

  // run bookkeeping
  int       polls_accepted = 0;
  int       failed_polls   = 0;
  int       reports_checked = 0;
  int       fires_seen     = 0;
  int       mismatches     = 0;
  bit [3:0] maps_used      = '0;
  int       cycle_count    = 0;

  // sender and receiver controls
  bit offering      = 1'b0;  // valid is being held high by the sender
  bit tx_gapless    = 1'b0;  // sender offers back to back
  int rx_hold_token = 0;     // bump to make the receiver hold off for a long stretch

  // center, dead zone and 4/3 scaling of one raw axis, rounded
  function automatic int scale_axis(input logic [AXIS_W-1:0] raw);
    int c;
    c = raw;
    c = c - MID;
    if (c < -DZ) return -(((-c - DZ) * 4 + 1) / 3);
    if (c > DZ) return ((c - DZ) * 4 + 1) / 3;
    return 0;
  endfunction

  // works out the report for one accepted poll and queues it
  function automatic void condition_poll(input in_item_t p);
    int               c0, c1, a0, a1, step;
    longint           sq, x, y, z, t, dx, dy;
    logic [BTN_W-1:0] raw, now;
    out_item_t        r;
    polls_accepted++;
    // a failed poll leaves no report and keeps the button history
    if (!p.poll_ok) begin
      failed_polls++;
      return;
    end
    c0 = scale_axis(p.axis_x);
    c1 = scale_axis(p.axis_y);
    case (model_map)
      MAP_RZ_SLIDER: begin
        a0 = scale_axis(p.axis_rot_z);
        a1 = scale_axis(p.slider_zero);
      end
      MAP_RZ_Z: begin
        a0 = scale_axis(p.axis_rot_z);
        a1 = scale_axis(p.axis_z);
      end
      MAP_Z_RZ: begin
        a0 = scale_axis(p.axis_z);
        a1 = scale_axis(p.axis_rot_z);
      end
      default: begin
        a0 = scale_axis(p.axis_rot_x);
        a1 = scale_axis(p.axis_rot_y);
      end
    endcase
    r = '0;
    // fire when the aim length is above 0.1, tested exactly on the squares
    sq = longint'(a0) * a0 + longint'(a1) * a1;
    r.fire = (sq * 100 > (longint'(1) << 30));
    if (r.fire) begin
      // pre-rotate into the right half plane, then cordic vectoring
      x = longint'(a1) * 256;
      y = longint'(a0) * 256;
      z = 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = QUARTER_TURN;
        end else begin
          t = x; x = -y; y = t; z = -QUARTER_TURN;
        end
      end
      for (step = 0; step < ANGLE_STEPS && step < 20; step++) begin
        dx = y >>> step;
        dy = x >>> step;
        if (y > 0) begin
          x += dx; y -= dy; z += arctan_q13[step];
        end else begin
          x -= dx; y += dy; z -= arctan_q13[step];
        end
      end
      if (z > HALF_TURN) z = HALF_TURN;
      if (z < -HALF_TURN) z = -HALF_TURN;
      r.aim_angle = z[ANGLE_W-1:0];
      fires_seen++;
    end
    raw = p.raw_buttons;
    // rx/ry layout also reorders the face buttons and drops the top four
    if (model_map == MAP_RX_RY)
      now = {4'b0, raw[11], raw[10], raw[4], raw[1], raw[3], raw[5], raw[0], raw[2]};
    else
      now = raw;
    r.move_left      = MAG_W'((c0 < 0) ? -c0 : 0);
    r.move_right     = MAG_W'((c0 < 0) ? 0 : c0);
    r.move_up        = MAG_W'((c1 < 0) ? -c1 : 0);
    r.move_down      = MAG_W'((c1 < 0) ? 0 : c1);
    r.buttons_now    = now;
    r.pressed_edges  = now & ~model_prev_buttons;
    r.released_edges = model_prev_buttons & ~now;
    model_prev_buttons = now;
    maps_used[model_map] = 1'b1;
    pending_reports.push_back(r);
  endfunction

  function automatic in_item_t make_poll(input logic [AXIS_W-1:0] ax, input logic [AXIS_W-1:0] ay,
                                         input logic [BTN_W-1:0] btn);
    in_item_t p;
    p = '0;
    p.poll_ok     = 1'b1;
    p.axis_x      = ax;
    p.axis_y      = ay;
    p.axis_z      = MID_RAW;
    p.axis_rot_x  = MID_RAW;
    p.axis_rot_y  = MID_RAW;
    p.axis_rot_z  = MID_RAW;
    p.slider_zero = MID_RAW;
    p.raw_buttons = btn;
    return p;
  endfunction

  // aim pair routed to the axes that the given layout reads; the move axes rest at
  // center and all others sit at full negative so a wrong routing would show up as fire
  function automatic in_item_t aim_poll(input axis_map_t m, input logic [AXIS_W-1:0] aim0,
                                        input logic [AXIS_W-1:0] aim1, input logic [BTN_W-1:0] btn);
    in_item_t p;
    p = '0;
    p.poll_ok     = 1'b1;
    p.axis_x      = MID_RAW;
    p.axis_y      = MID_RAW;
    p.raw_buttons = btn;
    case (m)
      MAP_RZ_SLIDER: begin
        p.axis_rot_z  = aim0;
        p.slider_zero = aim1;
      end
      MAP_RZ_Z: begin
        p.axis_rot_z = aim0;
        p.axis_z     = aim1;
      end
      MAP_Z_RZ: begin
        p.axis_z     = aim0;
        p.axis_rot_z = aim1;
      end
      default: begin
        p.axis_rot_x = aim0;
        p.axis_rot_y = aim1;
      end
    endcase
    return p;
  endfunction

  // raw axis biased toward the dead zone edges, the center, the fire threshold and the rails
  function automatic logic [AXIS_W-1:0] random_axis();
    int r, off;
    r = $urandom_range(0, 99);
    if (r < 30) return AXIS_W'($urandom_range(0, 65535));
    if (r < 50) off = DZ - 2 + $urandom_range(0, 4);
    else if (r < 65) off = $urandom_range(0, DZ);
    else if (r < 80) off = 10647 + $urandom_range(0, 6);
    else begin
      case ($urandom_range(0, 3))
        0: return 16'd0;
        1: return 16'd65535;
        2: return 16'd1;
        default: return 16'd65534;
      endcase
    end
    return $urandom_range(0, 1) ? AXIS_W'(MID + off) : AXIS_W'(MID - off);
  endfunction

  function automatic in_item_t random_poll();
    in_item_t p;
    int       r;
    p.poll_ok     = ($urandom_range(0, 9) != 0);
    p.axis_x      = random_axis();
    p.axis_y      = random_axis();
    p.axis_z      = random_axis();
    p.axis_rot_x  = random_axis();
    p.axis_rot_y  = random_axis();
    p.axis_rot_z  = random_axis();
    p.slider_zero = random_axis();
    r = $urandom_range(0, 99);
    // mostly fresh masks, some single-button toggles, a few all-up or all-down
    if (r < 60) p.raw_buttons = BTN_W'($urandom_range(0, 4095));
    else if (r < 85) p.raw_buttons = model_prev_buttons ^ (12'd1 << $urandom_range(0, 11));
    else p.raw_buttons = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    return p;
  endfunction

  // offers one poll after a random gap and returns at the edge where it is taken
  task automatic send_poll(input in_item_t p);
    int r, gap;
    r = $urandom_range(0, 99);
    if (tx_gapless || r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 96) gap = $urandom_range(4, 10);
    else gap = $urandom_range(30, 80);
    if (gap > 0 && offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_if.valid <= 1'b1;
    in_if.item  <= p;
    offering = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    condition_poll(p);
  endtask

  // stop offering and wait for every queued report
  task automatic wait_drained();
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // mapping writes only with the block idle: drained, plus time for a trailing failed poll
  task automatic write_mapping(input axis_map_t m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_map = m;
  endtask

  // move channels: rails, both dead zone edges, the first step past them and just off center
  task automatic test_move_axes();
    send_poll(make_poll(16'd0, 16'd65535, 12'hFFF));
    send_poll(make_poll(16'd65535, 16'd0, 12'h000));
    send_poll(make_poll(16'd24576, 16'd40960, 12'h001));
    send_poll(make_poll(16'd24575, 16'd40961, 12'h800));
    send_poll(make_poll(16'd32767, 16'd32769, 12'h000));
  endtask

  // a failed poll gives nothing and must not disturb the button history
  task automatic test_failed_poll();
    in_item_t p;
    send_poll(make_poll(MID_RAW, MID_RAW, 12'hF0F));
    p = make_poll(16'd65535, 16'd0, 12'h0F0);
    p.poll_ok = 1'b0;
    send_poll(p);
    send_poll(make_poll(MID_RAW, MID_RAW, 12'hF0F));
  endtask

  // every button rising or falling at least once
  task automatic test_button_edges();
    send_poll(make_poll(MID_RAW, MID_RAW, 12'hAAA));
    send_poll(make_poll(MID_RAW, MID_RAW, 12'h555));
  endtask

  // each layout: just above and just below the fire threshold, the left half
  // plane on either side, and the straight-back direction
  task automatic test_aim_mappings();
    axis_map_t m;
    for (int k = 0; k < 4; k++) begin
      m = axis_map_t'(k);
      write_mapping(m);
      send_poll(aim_poll(m, AIM_FIRE_RAW, MID_RAW, 12'hFFF));
      send_poll(aim_poll(m, AIM_QUIET_RAW, MID_RAW, 12'h401));
      send_poll(aim_poll(m, k[0] ? 16'd0 : 16'd65535, 16'd0, 12'h824));
      send_poll(aim_poll(m, MID_RAW, 16'd0, 12'h000));
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_backpressure();
    in_item_t p;
    wait_drained();
    rx_hold_token++;
    tx_gapless = 1'b1;
    for (int k = 0; k < PRESSURE_POLLS; k++) begin
      p = random_poll();
      p.poll_ok = 1'b1;
      send_poll(p);
    end
    tx_gapless = 1'b0;
  endtask

  // random polls in phases, stepping through all layouts, one phase with no sender gaps
  task automatic test_random_polls();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_mapping(axis_map_t'((phase + 3) % 4));
      tx_gapless = (phase == 2);
      for (int k = 0; k < RANDOM_POLLS / RANDOM_PHASES; k++)
        send_poll(random_poll());
    end
    tx_gapless = 1'b0;
  endtask

  // receiver: runs of ready and stalls, mostly short, a few long, some long open stretches
  initial begin
    int run_left, hold_seen, r;
    bit run_ready;
    run_left  = 0;
    hold_seen = 0;
    run_ready = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_token != hold_seen) begin
        hold_seen = rx_hold_token;
        run_ready = 1'b0;
        run_left  = LONG_HOLD_CYCLES;
      end else if (run_left <= 0) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          run_ready = 1'b1;
          run_left  = $urandom_range(200, 400);
        end else if (r < 50) begin
          run_ready = 1'b1;
          run_left  = $urandom_range(1, 20);
        end else if (r < 92) begin
          run_ready = 1'b0;
          run_left  = $urandom_range(1, 3);
        end else begin
          run_ready = 1'b0;
          run_left  = $urandom_range(20, 60);
        end
      end
      out_if.ready <= run_ready;
      run_left--;
    end
  end

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // every report taken is compared with the oldest prediction
  always @(posedge clk) begin : report_check
    out_item_t want, got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.item;
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report with no poll pending, expected none, actual %h", $time, got);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        check_field("move_left", want.move_left, got.move_left);
        check_field("move_right", want.move_right, got.move_right);
        check_field("move_up", want.move_up, got.move_up);
        check_field("move_down", want.move_down, got.move_down);
        check_field("aim_angle", $signed(want.aim_angle), $signed(got.aim_angle));
        check_field("fire", want.fire, got.fire);
        check_field("buttons_now", want.buttons_now, got.buttons_now);
        check_field("pressed_edges", want.pressed_edges, got.pressed_edges);
        check_field("released_edges", want.released_edges, got.released_edges);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d reports still pending", $time, cycle_count,
             pending_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= MAP_RZ_SLIDER;
    in_if.valid <= 1'b0;
    in_if.item  <= '0;
    model_map          = MAP_RZ_SLIDER;
    model_prev_buttons = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs on the reset layout first
    test_move_axes();
    test_failed_poll();
    test_button_edges();
    test_aim_mappings();
    test_backpressure();
    test_random_polls();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d polls taken (%0d failed), %0d reports checked, %0d with fire",
             polls_accepted, failed_polls, reports_checked, fires_seen);
    $display("layouts seen %b, with long receiver hold-off and drain pauses", maps_used);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
